@@ src/rational_arithmetic_unit_macros.svh @@
// Assertion macros used by the rational arithmetic unit RTL.
`ifndef RATIONAL_ARITHMETIC_UNIT_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RAU_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RAU_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/rau_pkg.sv @@
// Types and constants shared by the rational arithmetic unit modules.
package rau_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int PROD_WIDTH    = 2 * OPERAND_WIDTH;
   localparam int NUM_WIDTH     = 2 * OPERAND_WIDTH + 1;
   localparam int RES_NUM_WIDTH = 33;
   localparam int RES_DEN_WIDTH = 31;
   localparam int SHIFT_WIDTH   = $clog2(NUM_WIDTH);
   localparam int COUNT_WIDTH   = $clog2(NUM_WIDTH);
   localparam int QUEUE_DEPTH   = 2;
   localparam int QPTR_WIDTH    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      FUNC_ADD, FUNC_SUB, FUNC_MUL, FUNC_DIV
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK, STATUS_ZERO_DEN, STATUS_DIV_ZERO
   } status_type;

   typedef enum logic [2:0] {
      FR_IDLE, FR_MUL1, FR_MUL2, FR_MUL3, FR_SUM, FR_PUSH
   } front_state_type;

   typedef enum logic [1:0] {
      BK_IDLE, BK_GCD, BK_DIV, BK_OUT
   } back_state_type;

   typedef struct packed {
      status_type             status;
      logic                   neg;
      logic [NUM_WIDTH-1:0]   n_mag;
      logic [PROD_WIDTH-1:0]  d_mag;
   } entry_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

@@ src/rau_front.sv @@
// Front end: accepts requests, flags bad operands, forms the cross products.
module rau_front (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic [1:0]                                 req_func,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0]   req_a_num,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0]   req_a_den,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0]   req_b_num,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0]   req_b_den,
   input  logic                                       q_full,
   output logic                                       q_push,
   output rau_pkg::entry_type                         q_entry
);
   localparam int W  = rau_pkg::OPERAND_WIDTH;
   localparam int PW = rau_pkg::PROD_WIDTH;
   localparam int NW = rau_pkg::NUM_WIDTH;

   rau_pkg::front_state_type state_ff, state_in;
   rau_pkg::func_type        func_ff;
   rau_pkg::status_type      status_ff, status_in;
   logic signed [W-1:0]      an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [W-1:0]      mul_a, mul_b;
   logic signed [PW-1:0]     prod;
   logic signed [PW-1:0]     p1_ff, p2_ff, p3_ff;
   logic [NW-1:0]            n_sum;
   logic                     accept;
   rau_pkg::entry_type       entry_ff;

   assign accept = start && (state_ff == rau_pkg::FR_IDLE);
   assign prod   = mul_a * mul_b;

   always_comb begin
      if (req_a_den == '0 || req_b_den == '0) begin
         status_in = rau_pkg::STATUS_ZERO_DEN;
      end else if (rau_pkg::func_type'(req_func) == rau_pkg::FUNC_DIV && req_b_num == '0) begin
         status_in = rau_pkg::STATUS_DIV_ZERO;
      end else begin
         status_in = rau_pkg::STATUS_OK;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rau_pkg::FR_IDLE: begin
            if (start) begin
               state_in = (status_in == rau_pkg::STATUS_OK) ? rau_pkg::FR_MUL1
                                                            : rau_pkg::FR_SUM;
            end
         end
         rau_pkg::FR_MUL1: state_in = rau_pkg::FR_MUL2;
         rau_pkg::FR_MUL2: state_in = rau_pkg::FR_MUL3;
         rau_pkg::FR_MUL3: state_in = rau_pkg::FR_SUM;
         rau_pkg::FR_SUM:  state_in = rau_pkg::FR_PUSH;
         rau_pkg::FR_PUSH: begin
            if (!q_full) begin
               state_in = rau_pkg::FR_IDLE;
            end
         end
         default: state_in = rau_pkg::FR_IDLE;
      endcase
   end

   // outputs and multiplier operand select
   always_comb begin
      busy   = (state_ff != rau_pkg::FR_IDLE);
      q_push = (state_ff == rau_pkg::FR_PUSH) && !q_full;
      mul_a  = an_ff;
      mul_b  = bd_ff;
      case (state_ff)
         rau_pkg::FR_MUL1: begin
            mul_a = an_ff;
            mul_b = (func_ff == rau_pkg::FUNC_MUL) ? bn_ff : bd_ff;
         end
         rau_pkg::FR_MUL2: begin
            mul_a = (func_ff == rau_pkg::FUNC_DIV) ? bn_ff : bd_ff;
            mul_b = ad_ff;
         end
         rau_pkg::FR_MUL3: begin
            mul_a = bn_ff;
            mul_b = ad_ff;
         end
         default: begin
            mul_a = an_ff;
            mul_b = bd_ff;
         end
      endcase
   end

   always_comb begin
      case (func_ff)
         rau_pkg::FUNC_ADD: n_sum = {p1_ff[PW-1], p1_ff} + {p3_ff[PW-1], p3_ff};
         rau_pkg::FUNC_SUB: n_sum = {p1_ff[PW-1], p1_ff} - {p3_ff[PW-1], p3_ff};
         default:           n_sum = {p1_ff[PW-1], p1_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         rau_pkg::FR_IDLE: begin
            if (accept) begin
               func_ff   <= rau_pkg::func_type'(req_func);
               status_ff <= status_in;
               an_ff     <= req_a_num;
               ad_ff     <= req_a_den;
               bn_ff     <= req_b_num;
               bd_ff     <= req_b_den;
            end
         end
         rau_pkg::FR_MUL1: p1_ff <= prod;
         rau_pkg::FR_MUL2: p2_ff <= prod;
         rau_pkg::FR_MUL3: p3_ff <= prod;
         rau_pkg::FR_SUM: begin
            entry_ff.status <= status_ff;
            entry_ff.neg    <= n_sum[NW-1] ^ p2_ff[PW-1];
            entry_ff.n_mag  <= n_sum[NW-1] ? (~n_sum + 1'b1) : n_sum;
            entry_ff.d_mag  <= p2_ff[PW-1] ? (~p2_ff + 1'b1) : p2_ff;
         end
         default: begin
         end
      endcase
   end

   assign q_entry = entry_ff;

endmodule

@@ src/rau_queue.sv @@
// Two-entry queue between the front end and the reduction back end.
module rau_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  rau_pkg::queue_ctrl_type  ctrl,
   output rau_pkg::queue_stat_type  stat,
   input  rau_pkg::entry_type       wr_entry,
   output rau_pkg::entry_type       rd_entry
);
   localparam int D  = rau_pkg::QUEUE_DEPTH;
   localparam int PW = rau_pkg::QPTR_WIDTH;

   rau_pkg::entry_type   mem_ff [D];
   logic [PW-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]          count_ff;

   assign stat.full  = (count_ff == (PW+1)'(D));
   assign stat.empty = (count_ff == '0);
   assign rd_entry   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (ctrl.push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(D - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (ctrl.pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(D - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (ctrl.push && !ctrl.pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (ctrl.pop && !ctrl.push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

@@ src/rau_back.sv @@
// Back end: binary gcd, two serial dividers and the result strobe.
`include "rational_arithmetic_unit_macros.svh"
module rau_back (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       q_empty,
   output logic                                       q_pop,
   input  rau_pkg::entry_type                         q_entry,
   output logic                                       rsp_strobe,
   output logic signed [rau_pkg::RES_NUM_WIDTH-1:0]   rsp_res_num,
   output logic [rau_pkg::RES_DEN_WIDTH-1:0]          rsp_res_den,
   output logic [1:0]                                 rsp_status
);
   localparam int NW = rau_pkg::NUM_WIDTH;
   localparam int SW = rau_pkg::SHIFT_WIDTH;
   localparam int CW = rau_pkg::COUNT_WIDTH;

   rau_pkg::back_state_type state_ff, state_in;
   rau_pkg::status_type     status_ff;
   logic                    neg_ff;
   logic [NW-1:0]           nm_ff, dm_ff, x_ff, y_ff;
   logic [SW-1:0]           k_ff;
   logic [NW-1:0]           qn_ff, qd_ff;
   logic [NW:0]             rn_ff, rd_ff;
   logic [CW-1:0]           cnt_ff;
   logic                    trivial;
   logic [NW:0]             rn_sh, rd_sh, y_ext;
   logic [NW-1:0]           num_signed;

   assign trivial = (q_entry.status != rau_pkg::STATUS_OK) || (q_entry.n_mag == '0);
   assign y_ext   = {1'b0, y_ff};
   assign rn_sh   = {rn_ff[NW-1:0], qn_ff[NW-1]};
   assign rd_sh   = {rd_ff[NW-1:0], qd_ff[NW-1]};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rau_pkg::BK_IDLE: begin
            if (!q_empty) begin
               state_in = trivial ? rau_pkg::BK_OUT : rau_pkg::BK_GCD;
            end
         end
         rau_pkg::BK_GCD: begin
            if (x_ff == '0) begin
               state_in = rau_pkg::BK_DIV;
            end
         end
         rau_pkg::BK_DIV: begin
            if (cnt_ff == CW'(NW - 1)) begin
               state_in = rau_pkg::BK_OUT;
            end
         end
         rau_pkg::BK_OUT: state_in = rau_pkg::BK_IDLE;
         default:         state_in = rau_pkg::BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop      = (state_ff == rau_pkg::BK_IDLE) && !q_empty;
      rsp_strobe = (state_ff == rau_pkg::BK_OUT);
   end

   assign num_signed  = neg_ff ? (~qn_ff + 1'b1) : qn_ff;
   assign rsp_res_num = rau_pkg::RES_NUM_WIDTH'(signed'(num_signed));
   assign rsp_res_den = rau_pkg::RES_DEN_WIDTH'(qd_ff);
   assign rsp_status  = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         rau_pkg::BK_IDLE: begin
            if (!q_empty) begin
               status_ff <= q_entry.status;
               neg_ff    <= q_entry.neg && !trivial;
               nm_ff     <= q_entry.n_mag;
               dm_ff     <= NW'(q_entry.d_mag);
               x_ff      <= q_entry.n_mag;
               y_ff      <= NW'(q_entry.d_mag);
               k_ff      <= '0;
               qn_ff     <= '0;
               qd_ff     <= NW'(1);
            end
         end
         rau_pkg::BK_GCD: begin
            if (x_ff == '0) begin
               // gcd is y << k: strip the power of two now, divide by the odd part
               qn_ff  <= nm_ff >> k_ff;
               qd_ff  <= dm_ff >> k_ff;
               rn_ff  <= '0;
               rd_ff  <= '0;
               cnt_ff <= '0;
            end else if (!x_ff[0] && !y_ff[0]) begin
               x_ff <= x_ff >> 1;
               y_ff <= y_ff >> 1;
               k_ff <= k_ff + 1'b1;
            end else if (!x_ff[0]) begin
               x_ff <= x_ff >> 1;
            end else if (!y_ff[0]) begin
               y_ff <= y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_ff <= (x_ff - y_ff) >> 1;
            end else begin
               y_ff <= (y_ff - x_ff) >> 1;
            end
         end
         rau_pkg::BK_DIV: begin
            cnt_ff <= cnt_ff + 1'b1;
            if (rn_sh >= y_ext) begin
               rn_ff <= rn_sh - y_ext;
               qn_ff <= {qn_ff[NW-2:0], 1'b1};
            end else begin
               rn_ff <= rn_sh;
               qn_ff <= {qn_ff[NW-2:0], 1'b0};
            end
            if (rd_sh >= y_ext) begin
               rd_ff <= rd_sh - y_ext;
               qd_ff <= {qd_ff[NW-2:0], 1'b1};
            end else begin
               rd_ff <= rd_sh;
               qd_ff <= {qd_ff[NW-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   `RAU_ASSERT_NXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe, "strobe held twice")
   `RAU_ASSERT_IMP(a_gcd_divisor, clock, reset, state_ff == rau_pkg::BK_GCD, y_ff != '0, "gcd divisor zero")
   `RAU_ASSERT_IMP(a_err_zero, clock, reset, rsp_strobe && rsp_status != rau_pkg::STATUS_OK, rsp_res_num == '0 && rsp_res_den == rau_pkg::RES_DEN_WIDTH'(1), "error result not 0/1")
   `RAU_ASSERT_IMP(a_pop_idle, clock, reset, q_pop, state_ff == rau_pkg::BK_IDLE && !q_empty, "pop outside idle")

endmodule

@@ src/rational_arithmetic_unit.sv @@
// Rational arithmetic unit: add, subtract, multiply or divide two fractions in lowest terms.
//
// Request channel: drive req_func and the four operands with start high; the
// request transfers at a rising edge where start is high and busy is low.
// Result channel: rsp_strobe is high for exactly one cycle with rsp_res_num,
// rsp_res_den (positive) and rsp_status; the receiver cannot stall it.
// After a transfer the front end is busy through three products on one shared
// multiplier, a sum and a queue write (only the sum and the write for an error
// request), and waits in the queue write while the two-entry queue is full.
// The back end runs a queue read, binary-gcd steps (as many as the operand bits
// call for), a step to pick out the gcd, two serial dividers sharing a count,
// and the strobe.
// A zero denominator or division by a zero fraction skips straight from the
// queue read to the strobe with an error status and 0/1.
// Sustained throughput is one item per back-end run.
// Synchronous reset empties the queue and returns both ends to idle; results
// in flight are dropped.
module rational_arithmetic_unit (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       start,
   output logic                                       busy,
   input  logic [1:0]                                 req_func,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0]   req_a_num,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0]   req_a_den,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0]   req_b_num,
   input  logic signed [rau_pkg::OPERAND_WIDTH-1:0]   req_b_den,
   output logic                                       rsp_strobe,
   output logic signed [rau_pkg::RES_NUM_WIDTH-1:0]   rsp_res_num,
   output logic [rau_pkg::RES_DEN_WIDTH-1:0]          rsp_res_den,
   output logic [1:0]                                 rsp_status
);
   rau_pkg::queue_ctrl_type qctrl;
   rau_pkg::queue_stat_type qstat;
   rau_pkg::entry_type      wr_entry, rd_entry;

   rau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_func  (req_func),
      .req_a_num (req_a_num),
      .req_a_den (req_a_den),
      .req_b_num (req_b_num),
      .req_b_den (req_b_den),
      .q_full    (qstat.full),
      .q_push    (qctrl.push),
      .q_entry   (wr_entry)
   );

   rau_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (qctrl),
      .stat     (qstat),
      .wr_entry (wr_entry),
      .rd_entry (rd_entry)
   );

   rau_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (qstat.empty),
      .q_pop       (qctrl.pop),
      .q_entry     (rd_entry),
      .rsp_strobe  (rsp_strobe),
      .rsp_res_num (rsp_res_num),
      .rsp_res_den (rsp_res_den),
      .rsp_status  (rsp_status)
   );

endmodule
